// File: hw/rtl/iorr_pkg.sv
package iorr_pkg;

   // default build
   localparam int WINDOW_DEF   = 32;
   localparam int SEQ_BITS_DEF = 16;
   localparam int TAG_BITS_DEF = 16;

   // fixed port widths
   localparam int PORT_SEQ_W = 16;
   localparam int PORT_TAG_W = 16;

   // result kinds
   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // status codes
   localparam logic [1:0] ST_ACCEPT  = 2'd0;
   localparam logic [1:0] ST_CLOSED  = 2'd1;
   localparam logic [1:0] ST_DUP     = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   // sequencer to slot store
   typedef struct packed {
      logic ins;   // store a new entry, set its flag
      logic rd;    // read entry at head
      logic rel;   // drop flag at head
   } slot_ctl_type;

endpackage

// File: hw/rtl/iorr_win_calc.sv
module iorr_win_calc #(
   parameter int WINDOW   = iorr_pkg::WINDOW_DEF,
   parameter int SEQ_BITS = iorr_pkg::SEQ_BITS_DEF,
   parameter int IDX_W    = $clog2(WINDOW)
) (
   input  logic [SEQ_BITS-1:0] seq,
   input  logic [SEQ_BITS-1:0] next_seq,
   input  logic [IDX_W-1:0]    head,
   output logic                in_window,
   output logic                dist_zero,
   output logic [IDX_W-1:0]    slot
);

   localparam int CW = (SEQ_BITS > 7) ? SEQ_BITS : 7;

   logic [SEQ_BITS-1:0] gap;
   logic [CW-1:0]       gap_w;
   logic [IDX_W:0]      sum;

   // distance modulo the sequence space
   assign gap       = seq - next_seq;
   assign gap_w     = CW'(gap);
   assign in_window = gap_w < CW'(WINDOW);
   assign dist_zero = (gap == '0);

   // ring position, one subtract of the window at most
   assign sum  = (IDX_W+1)'(head) + (IDX_W+1)'(IDX_W'(gap));
   assign slot = (sum >= (IDX_W+1)'(WINDOW)) ? IDX_W'(sum - (IDX_W+1)'(WINDOW))
                                            : IDX_W'(sum);

endmodule

// File: hw/rtl/iorr_slot_store.sv
module iorr_slot_store #(
   parameter int WINDOW   = iorr_pkg::WINDOW_DEF,
   parameter int TAG_BITS = iorr_pkg::TAG_BITS_DEF,
   parameter int IDX_W    = $clog2(WINDOW)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  iorr_pkg::slot_ctl_type ctl,
   input  logic [IDX_W-1:0]     wr_idx,
   input  logic [TAG_BITS:0]    wr_entry,
   input  logic [IDX_W-1:0]     head_idx,
   input  logic [IDX_W-1:0]     nxt_idx,
   output logic                 wr_busy,
   output logic                 head_valid,
   output logic                 nxt_valid,
   output logic [TAG_BITS:0]    rd_entry
);

   logic [WINDOW-1:0] valid_ff;
   logic [WINDOW-1:0] valid_in;
   logic [TAG_BITS:0] ram [0:WINDOW-1];
   logic [TAG_BITS:0] rd_entry_ff;

   assign wr_busy    = valid_ff[wr_idx];
   assign head_valid = valid_ff[head_idx];
   assign nxt_valid  = valid_ff[nxt_idx];
   assign rd_entry   = rd_entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.ins) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (ctl.rel) begin
         valid_in[head_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         ram[wr_idx] <= wr_entry;
      end
      if (ctl.rd) begin
         rd_entry_ff <= ram[head_idx];
      end
   end

endmodule

// File: hw/rtl/in_order_response_release.sv
// The request is captured, then the check state loads the status result into the output
// register once it is free. Each release then reads the entry memory, then loads the output.
// Requests are refused (req_stall high) until the sequencer returns to idle.
// Reset (synchronous): clears slot flags, head, next sequence and closed state.
// Entry memory is not cleared; no entry is read before its flag is set.
module in_order_response_release #(
   parameter int WINDOW   = iorr_pkg::WINDOW_DEF,
   parameter int SEQ_BITS = iorr_pkg::SEQ_BITS_DEF,
   parameter int TAG_BITS = iorr_pkg::TAG_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [iorr_pkg::PORT_SEQ_W-1:0] req_seq_num,
   input  logic [iorr_pkg::PORT_TAG_W-1:0] req_payload_tag,
   input  logic                            req_close_after,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_item_kind,
   output logic [1:0]                      rsp_status_code,
   output logic [iorr_pkg::PORT_SEQ_W-1:0] rsp_out_seq,
   output logic [iorr_pkg::PORT_TAG_W-1:0] rsp_out_tag,
   output logic                            rsp_shutdown,
   output logic                            rsp_last
);

   localparam int IDX_W = $clog2(WINDOW);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a request
   localparam logic [1:0] S_CHECK = 2'd1;  // classify, store, emit status
   localparam logic [1:0] S_READ  = 2'd2;  // read entry at head
   localparam logic [1:0] S_DATA  = 2'd3;  // emit release, advance head

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [SEQ_BITS-1:0] next_seq_ff, next_seq_in;
   logic                closed_ff, closed_in;

   // captured request
   logic [SEQ_BITS-1:0] cap_seq_ff, cap_seq_in;
   logic [TAG_BITS-1:0] cap_tag_ff, cap_tag_in;
   logic                cap_cls_ff, cap_cls_in;

   // output register
   logic                            out_valid_ff, out_valid_in;
   logic                            out_kind_ff, out_kind_in;
   logic [1:0]                      out_code_ff, out_code_in;
   logic [iorr_pkg::PORT_SEQ_W-1:0] out_seq_ff, out_seq_in;
   logic [iorr_pkg::PORT_TAG_W-1:0] out_tag_ff, out_tag_in;
   logic                            out_shut_ff, out_shut_in;
   logic                            out_last_ff, out_last_in;

   logic                   out_free;
   logic                   in_window;
   logic                   dist_zero;
   logic [IDX_W-1:0]       slot;
   logic [IDX_W-1:0]       nxt_idx;
   logic [IDX_W:0]         head_inc;
   logic                   wr_busy;
   logic                   head_valid;
   logic                   nxt_valid;
   logic [TAG_BITS:0]      rd_entry;
   iorr_pkg::slot_ctl_type ctl;

   // output register can take a result this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   // head + 1 around the ring
   assign head_inc = (IDX_W+1)'(head_ff) + (IDX_W+1)'(1);
   assign nxt_idx  = (head_inc == (IDX_W+1)'(WINDOW)) ? '0 : IDX_W'(head_inc);

   iorr_win_calc #(
      .WINDOW   (WINDOW),
      .SEQ_BITS (SEQ_BITS),
      .IDX_W    (IDX_W)
   ) u_win (
      .seq       (cap_seq_ff),
      .next_seq  (next_seq_ff),
      .head      (head_ff),
      .in_window (in_window),
      .dist_zero (dist_zero),
      .slot      (slot)
   );

   iorr_slot_store #(
      .WINDOW   (WINDOW),
      .TAG_BITS (TAG_BITS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_idx     (slot),
      .wr_entry   ({cap_tag_ff, cap_cls_ff}),
      .head_idx   (head_ff),
      .nxt_idx    (nxt_idx),
      .wr_busy    (wr_busy),
      .head_valid (head_valid),
      .nxt_valid  (nxt_valid),
      .rd_entry   (rd_entry)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      next_seq_in  = next_seq_ff;
      closed_in    = closed_ff;
      cap_seq_in   = cap_seq_ff;
      cap_tag_in   = cap_tag_ff;
      cap_cls_in   = cap_cls_ff;
      // a shown result stays until taken
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_code_in  = out_code_ff;
      out_seq_in   = out_seq_ff;
      out_tag_in   = out_tag_ff;
      out_shut_in  = out_shut_ff;
      out_last_in  = out_last_ff;
      ctl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cap_seq_in = SEQ_BITS'(req_seq_num);
               cap_tag_in = TAG_BITS'(req_payload_tag);
               cap_cls_in = req_close_after;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = iorr_pkg::KIND_STATUS;
               out_seq_in   = '0;
               out_tag_in   = '0;
               out_shut_in  = 1'b0;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (closed_ff) begin
                  out_code_in = iorr_pkg::ST_CLOSED;
               end else if (!in_window) begin
                  out_code_in = iorr_pkg::ST_OUTSIDE;
               end else if (wr_busy) begin
                  out_code_in = iorr_pkg::ST_DUP;
               end else begin
                  // stored; head slot is empty at rest, so a release
                  // follows only when this request fills the head slot
                  out_code_in = iorr_pkg::ST_ACCEPT;
                  ctl.ins     = 1'b1;
                  out_last_in = !dist_zero;
                  if (dist_zero) begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            ctl.rd   = 1'b1;
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = iorr_pkg::KIND_RELEASE;
               out_code_in  = iorr_pkg::ST_ACCEPT;
               out_seq_in   = iorr_pkg::PORT_SEQ_W'(next_seq_ff);
               out_tag_in   = iorr_pkg::PORT_TAG_W'(rd_entry[TAG_BITS:1]);
               out_shut_in  = rd_entry[0];
               out_last_in  = rd_entry[0] || !nxt_valid;
               ctl.rel      = 1'b1;
               head_in      = nxt_idx;
               next_seq_in  = next_seq_ff + SEQ_BITS'(1);
               if (rd_entry[0]) begin
                  // close flag: latch closed, stop releasing
                  closed_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (nxt_valid) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         next_seq_ff  <= '0;
         closed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         next_seq_ff  <= next_seq_in;
         closed_ff    <= closed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      cap_seq_ff  <= cap_seq_in;
      cap_tag_ff  <= cap_tag_in;
      cap_cls_ff  <= cap_cls_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_seq_ff  <= out_seq_in;
      out_tag_ff  <= out_tag_in;
      out_shut_ff <= out_shut_in;
      out_last_ff <= out_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_item_kind   = out_kind_ff;
   assign rsp_status_code = out_code_ff;
   assign rsp_out_seq     = out_seq_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_shutdown    = out_shut_ff;
   assign rsp_last        = out_last_ff;

   // head slot is empty whenever the sequencer rests on an open stream
   a_head_empty_at_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !closed_ff) |-> !head_valid)
      else $error("head slot filled while idle");

   // a new entry never overwrites a filled slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |-> !wr_busy)
      else $error("store into filled slot");

   // a release carrying the close flag leaves the stream closed
   a_close_latch: assert property (@(posedge clock) disable iff (reset)
      (ctl.rel && rd_entry[0]) |=> (closed_ff && state_ff == S_IDLE))
      else $error("stream not closed after shutdown release");

   // release results always carry the accepted code
   a_release_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == iorr_pkg::KIND_RELEASE)
         |-> (rsp_status_code == iorr_pkg::ST_ACCEPT))
      else $error("release with non-accept code");

endmodule
